FILE: design/assert_macros.svh
// Assertion macros shared by the checker files of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on clk, off while rst_n is low.
`define SHF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition at one edge forces a signal to hold until the next edge.
`define SHF_ASSERT_HOLD(lbl, cond, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (cond) |=> $stable(sig)) else $error(msg);

`endif

FILE: design/shf32_pkg.sv
// Types, constants and mixing functions of the 32-bit SuperFastHash block.
`timescale 1ns / 1ps

package shf32_pkg;

  localparam int unsigned HashW = 32;

  // Class of a word, set by its valid byte count
  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_T1,
    KIND_T2,
    KIND_T3,
    KIND_FULL
  } kind_t;

  // One classified request as held in the queue
  typedef struct packed {
    logic [HashW-1:0] total_length;
    logic [HashW-1:0] data_word;
    kind_t            kind;
    logic             first;
    logic             last;
  } item_t;

  // Back end to finishing pipeline
  typedef struct packed {
    logic             vld;    // a last word enters the finisher
    logic             clr;    // a first word was issued: drop older write-backs
    logic             empty;  // message was started with zero length
    logic [HashW-1:0] hash;
  } iss_t;

  // Finishing pipeline to back end
  typedef struct packed {
    logic             ready;  // finisher can take a word this cycle
    logic             stale;  // a finished hash is still due to write back
    logic             wb_vld;
    logic [HashW-1:0] wb_hash;
  } fb_t;

  function automatic logic [HashW-1:0] sext8(input logic [7:0] b);
    sext8 = {{(HashW-8){b[7]}}, b};
  endfunction

  // One round over a word: full round or the tail mix of a short word
  function automatic logic [HashW-1:0] mix_word(input logic [HashW-1:0] h_in,
                                                 input logic [HashW-1:0] w,
                                                 input kind_t kind);
    logic [HashW-1:0] h;
    logic [HashW-1:0] t;
    h = h_in;
    t = '0;
    unique case (kind)
      KIND_FULL: begin
        h = h + {16'd0, w[15:0]};
        t = {16'd0, w[31:16]} << 11;
        t = t ^ h;
        h = (h << 16) ^ t;
        h = h + (h >> 11);
      end
      KIND_T3: begin
        h = h + {16'd0, w[15:0]};
        h = h ^ (h << 16);
        h = h ^ (sext8(w[23:16]) << 18);
        h = h + (h >> 11);
      end
      KIND_T2: begin
        h = h + {16'd0, w[15:0]};
        h = h ^ (h << 11);
        h = h + (h >> 17);
      end
      KIND_T1: begin
        h = h + sext8(w[7:0]);
        h = h ^ (h << 10);
        h = h + (h >> 1);
      end
      default: begin
        h = h_in;
      end
    endcase
    mix_word = h;
  endfunction

  // Final avalanche, split into three steps of one add each
  function automatic logic [HashW-1:0] aval_a(input logic [HashW-1:0] h_in);
    logic [HashW-1:0] h;
    h = h_in ^ (h_in << 3);
    aval_a = h + (h >> 5);
  endfunction

  function automatic logic [HashW-1:0] aval_b(input logic [HashW-1:0] h_in);
    logic [HashW-1:0] h;
    h = h_in ^ (h_in << 4);
    aval_b = h + (h >> 17);
  endfunction

  function automatic logic [HashW-1:0] aval_c(input logic [HashW-1:0] h_in);
    logic [HashW-1:0] h;
    h = h_in ^ (h_in << 25);
    aval_c = h + (h >> 6);
  endfunction

endpackage

FILE: design/superfast_hash32_top.sv
// Path from request accept to out_valid: input queue, avalanche stages and output register.
// Throughput: one word per cycle unless out_stall holds; a word without first that follows a last
// waits (longer while out_stall holds) for the finished hash to return.
// Input queue holds 2 requests; output register decouples a stalled consumer.
// Synchronous active-low reset empties queue and pipe, clears running hash.
`timescale 1ns / 1ps

module superfast_hash32_top import shf32_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_total_length,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_valid_bytes,
  input  logic        in_first,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_hash_value
);

  logic  q_vld;
  item_t q_item;
  logic  q_pop;
  iss_t  iss;
  fb_t   fb;

  // Accept and classify
  shf32_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_total_length (in_total_length),
    .in_data_word    (in_data_word),
    .in_valid_bytes  (in_valid_bytes),
    .in_first        (in_first),
    .in_last         (in_last),
    .q_vld           (q_vld),
    .q_item          (q_item),
    .q_pop           (q_pop)
  );

  // Per-word rounds
  shf32_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_vld  (q_vld),
    .q_item (q_item),
    .q_pop  (q_pop),
    .iss    (iss),
    .fb     (fb)
  );

  // Avalanche and output
  shf32_aval u_aval (
    .clk            (clk),
    .rst_n          (rst_n),
    .iss            (iss),
    .fb             (fb),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hash_value (out_hash_value)
  );

endmodule

FILE: design/shf32_front.sv
// Front end: takes input requests, classifies them and queues them.
`timescale 1ns / 1ps

module shf32_front import shf32_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_total_length,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_valid_bytes,
  input  logic        in_first,
  input  logic        in_last,
  output logic        q_vld,
  output item_t       q_item,
  input  logic        q_pop
);

  localparam int unsigned QDepth = 2;

  item_t       q_mem_r [QDepth];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        push;
  logic        pop;
  kind_t       kind;
  item_t       new_item;

  // Byte count to word class; counts above four act as a full word
  always_comb begin
    unique case (in_valid_bytes)
      3'd0:    kind = KIND_NONE;
      3'd1:    kind = KIND_T1;
      3'd2:    kind = KIND_T2;
      3'd3:    kind = KIND_T3;
      default: kind = KIND_FULL;
    endcase
  end

  always_comb begin
    new_item.total_length = in_total_length;
    new_item.data_word    = in_data_word;
    new_item.kind         = kind;
    new_item.first        = in_first;
    new_item.last         = in_last;
  end

  // Queue control
  assign in_stall = (count_r == 2'(QDepth));
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_vld;
  assign q_vld    = (count_r != 2'd0);
  assign q_item   = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

FILE: design/shf32_back.sv
// Back end: runs the per-word round and keeps the running hash.
`timescale 1ns / 1ps

module shf32_back import shf32_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  q_vld,
  input  item_t q_item,
  output logic  q_pop,
  output iss_t  iss,
  input  fb_t   fb
);

  logic [HashW-1:0] running_hash_r, running_hash_nxt;
  logic             empty_r, empty_nxt;
  logic             can_issue;
  logic [HashW-1:0] base;
  logic [HashW-1:0] h;
  logic             empty_cur;

  // A word without first needs the finished hash of the previous message
  assign can_issue = q_vld && (q_item.first || !fb.stale) && (!q_item.last || fb.ready);
  assign q_pop     = can_issue;

  always_comb begin
    base      = q_item.first ? q_item.total_length : running_hash_r;
    h         = mix_word(base, q_item.data_word, q_item.kind);
    empty_cur = q_item.first ? (q_item.total_length == '0) : empty_r;
  end

  always_comb begin
    iss.vld   = can_issue && q_item.last;
    iss.clr   = can_issue && q_item.first;
    iss.empty = empty_cur;
    iss.hash  = h;
  end

  // Issued word wins over a late write-back of a finished hash
  always_comb begin
    priority if (can_issue) begin
      running_hash_nxt = h;
    end else if (fb.wb_vld) begin
      running_hash_nxt = fb.wb_hash;
    end else begin
      running_hash_nxt = running_hash_r;
    end
    empty_nxt = can_issue ? empty_cur : empty_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_hash_r <= '0;
      empty_r        <= 1'b0;
    end else begin
      running_hash_r <= running_hash_nxt;
      empty_r        <= empty_nxt;
    end
  end

endmodule

FILE: design/shf32_aval.sv
// Finishing pipeline: three avalanche steps and the output register.
`timescale 1ns / 1ps

module shf32_aval import shf32_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  iss_t        iss,
  output fb_t         fb,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_hash_value
);

  localparam int unsigned Stages = 3;

  logic [Stages-1:0] st_vld_r, st_vld_nxt;
  logic [Stages-1:0] st_wb_r, st_wb_nxt;
  logic [Stages-1:0] st_empty_r, st_empty_nxt;
  logic [HashW-1:0]  st_hash_r [Stages];
  logic [HashW-1:0]  st_hash_nxt [Stages];
  logic              out_valid_r, out_valid_nxt;
  logic [HashW-1:0]  out_hash_r, out_hash_nxt;
  logic              adv;
  logic [HashW-1:0]  h1, h2, h3;

  // Whole pipeline moves when the output register is free or drains
  assign adv = !out_valid_r || !out_stall;

  always_comb begin
    h1 = aval_a(st_hash_r[0]);
    h2 = aval_b(st_hash_r[1]);
    h3 = aval_c(st_hash_r[2]);
  end

  // Only the youngest finished hash writes back into the running hash
  always_comb begin
    fb.ready   = adv;
    fb.stale   = |(st_vld_r & st_wb_r);
    fb.wb_vld  = adv && st_vld_r[2] && st_wb_r[2] && !iss.clr;
    fb.wb_hash = h3;
  end

  always_comb begin
    st_vld_nxt     = st_vld_r;
    st_wb_nxt      = st_wb_r & ~{Stages{iss.clr}};
    st_empty_nxt   = st_empty_r;
    st_hash_nxt[0] = st_hash_r[0];
    st_hash_nxt[1] = st_hash_r[1];
    st_hash_nxt[2] = st_hash_r[2];
    out_valid_nxt  = out_valid_r;
    out_hash_nxt   = out_hash_r;
    if (adv) begin
      st_vld_nxt     = {st_vld_r[Stages-2:0], iss.vld};
      st_wb_nxt      = {st_wb_r[Stages-2:0] & ~{(Stages-1){iss.clr}}, iss.vld};
      st_empty_nxt   = {st_empty_r[Stages-2:0], iss.empty};
      st_hash_nxt[0] = iss.hash;
      st_hash_nxt[1] = h1;
      st_hash_nxt[2] = h2;
      out_valid_nxt  = st_vld_r[2];
      out_hash_nxt   = st_empty_r[2] ? '0 : h3;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_vld_r    <= '0;
      st_wb_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_vld_r    <= st_vld_nxt;
      st_wb_r     <= st_wb_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    st_empty_r   <= st_empty_nxt;
    st_hash_r[0] <= st_hash_nxt[0];
    st_hash_r[1] <= st_hash_nxt[1];
    st_hash_r[2] <= st_hash_nxt[2];
    out_hash_r   <= out_hash_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

endmodule

FILE: design/shf32_checker.sv
// Port-level checker for the hash block and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module shf32_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_hash_value
);

  localparam logic [2:0] MaxInFlight = 3'd6;

  logic [2:0] pend_r;
  logic       in_last_acc;
  logic       out_acc;

  // Last-word requests accepted whose hash is not yet delivered
  assign in_last_acc = in_valid && !in_stall && in_last;
  assign out_acc     = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 3'd0;
    end else begin
      pend_r <= pend_r + {2'd0, in_last_acc} - {2'd0, out_acc};
    end
  end

  `SHF_ASSERT(a_no_result_without_last, out_valid |-> (pend_r != 3'd0), "result without last word")
  `SHF_ASSERT(a_in_flight_bound, pend_r <= MaxInFlight, "more messages in flight than storage")
  `SHF_ASSERT_HOLD(a_out_hold, out_valid && out_stall, out_hash_value, "stalled hash changed")
  `SHF_ASSERT(a_out_valid_hold, out_valid && out_stall |=> out_valid, "stalled result dropped")

endmodule

bind superfast_hash32_top shf32_checker u_shf32_checker (.*);

FILE: test/testbench.sv
// Self-checking testbench for the streaming 32-bit SuperFastHash block.
`timescale 1ns / 1ps

module testbench import shf32_pkg::*; ();

  localparam int unsigned RANDOM_REQS = 1600;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct {
    logic [31:0] total_length;
    logic [31:0] data_word;
    logic [2:0]  valid_bytes;
    logic        first;
    logic        last;
  } hash_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_total_length = '0;
  logic [31:0] in_data_word = '0;
  logic [2:0]  in_valid_bytes = '0;
  logic        in_first = 1'b0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_hash_value;

  hash_req_t   pending_reqs[$];
  hash_req_t   held_req;
  logic [31:0] expected_hashes[$];

  // predictor state
  logic [31:0] chain_hash = '0;
  logic        empty_seed = 1'b0;

  int unsigned total_reqs = 0;
  int unsigned accepted_reqs = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned quiet_cycles = 0;
  logic [31:0] exp_hash;

  wire in_fire = in_valid && !in_stall;
  wire out_fire = out_valid && !out_stall;
  // no idling on either side inside this window
  wire calm = (cycle_count >= 1200) && (cycle_count < 2200);

  superfast_hash32_top DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_total_length(in_total_length),
    .in_data_word   (in_data_word),
    .in_valid_bytes (in_valid_bytes),
    .in_first       (in_first),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hash_value (out_hash_value)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic logic [31:0] widen_signed_byte(input logic [7:0] b);
    return {{24{b[7]}}, b};
  endfunction

  function automatic kind_t classify_count(input logic [2:0] nb);
    unique case (nb)
      3'd0: return KIND_NONE;
      3'd1: return KIND_T1;
      3'd2: return KIND_T2;
      3'd3: return KIND_T3;
      default: return KIND_FULL;
    endcase
  endfunction

  function automatic logic [31:0] absorb_word(input logic [31:0] h_in,
                                              input logic [31:0] w,
                                              input kind_t kind);
    logic [31:0] h;
    logic [31:0] upper;
    h = h_in;
    upper = {16'd0, w[31:16]};
    case (kind)
      KIND_FULL: begin
        h = h + {16'd0, w[15:0]};
        upper = (upper << 11) ^ h;
        h = (h << 16) ^ upper;
        h = h + (h >> 11);
      end
      KIND_T3: begin
        h = h + {16'd0, w[15:0]};
        h = h ^ (h << 16);
        h = h ^ (widen_signed_byte(w[23:16]) << 18);
        h = h + (h >> 11);
      end
      KIND_T2: begin
        h = h + {16'd0, w[15:0]};
        h = h ^ (h << 11);
        h = h + (h >> 17);
      end
      KIND_T1: begin
        h = h + widen_signed_byte(w[7:0]);
        h = h ^ (h << 10);
        h = h + (h >> 1);
      end
      default: begin
      end
    endcase
    return h;
  endfunction

  function automatic logic [31:0] finish_hash(input logic [31:0] h_in);
    logic [31:0] h;
    h = h_in;
    h = h ^ (h << 3);
    h = h + (h >> 5);
    h = h ^ (h << 4);
    h = h + (h >> 17);
    h = h ^ (h << 25);
    h = h + (h >> 6);
    return h;
  endfunction

  // Fold one accepted request into the running hash; last emits the digest
  task automatic absorb_request(input hash_req_t r);
    logic [31:0] h;
    if (r.first) begin
      chain_hash = r.total_length;
      empty_seed = (r.total_length == 32'd0);
    end
    h = absorb_word(chain_hash, r.data_word, classify_count(r.valid_bytes));
    if (r.last) begin
      h = finish_hash(h);
      expected_hashes.insert(expected_hashes.size(), empty_seed ? 32'd0 : h);
    end
    chain_hash = h;
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic queue_req(input logic [31:0] len, input logic [31:0] word,
                           input logic [2:0] nb, input logic first,
                           input logic last);
    hash_req_t r;
    r.total_length = len;
    r.data_word = word;
    r.valid_bytes = nb;
    r.first = first;
    r.last = last;
    pending_reqs.insert(pending_reqs.size(), r);
    total_reqs++;
  endtask

  // A message of random content, mostly well formed, sometimes broken
  task automatic queue_message();
    int unsigned full_words;
    int unsigned tail_bytes;
    logic [31:0] len;
    logic        drop_first;
    logic        drop_last;
    full_words = ($urandom_range(99) < 90) ? $urandom_range(0, 6) : $urandom_range(7, 24);
    tail_bytes = $urandom_range(0, 3);
    len = 4 * full_words + tail_bytes;
    if ($urandom_range(99) < 10) len = $urandom;
    drop_first = ($urandom_range(99) < 5);
    drop_last = ($urandom_range(99) < 5);
    if (full_words == 0 && tail_bytes == 0) begin
      queue_req(len, $urandom, 3'($urandom_range(0, 4)), !drop_first, !drop_last);
      return;
    end
    for (int unsigned i = 0; i < full_words; i++) begin
      // an occasional short word in mid stream
      if ($urandom_range(99) < 3)
        queue_req(len, $urandom, 3'($urandom_range(1, 3)), i == 0 && !drop_first, 1'b0);
      else
        queue_req(len, $urandom, 3'd4, i == 0 && !drop_first,
                  (i == full_words - 1) && tail_bytes == 0 && !drop_last);
    end
    if (tail_bytes != 0)
      queue_req(len, $urandom, tail_bytes[2:0], full_words == 0 && !drop_first, !drop_last);
  endtask

  task automatic queue_noise();
    queue_req($urandom, $urandom, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)));
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        absorb_request(held_req);
        accepted_reqs++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= 16)) begin
          held_req = pending_reqs.pop_front();
          in_total_length <= held_req.total_length;
          in_data_word <= held_req.data_word;
          in_valid_bytes <= held_req.valid_bytes;
          in_first <= held_req.first;
          in_last <= held_req.last;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic report_error(input string what, input logic [31:0] want,
                              input logic [31:0] got);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_fire) begin
        if (expected_hashes.size() == 0) begin
          report_error("hash with no request pending", 32'd0, out_hash_value);
        end else begin
          exp_hash = expected_hashes.pop_front();
          if (out_hash_value !== exp_hash)
            report_error("hash_value differs", exp_hash, out_hash_value);
        end
      end
      out_stall <= !calm && ($urandom_range(99) < 16);
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk) begin
    cycle_count++;
    if (rst_n) begin
      if (in_fire || out_fire || (accepted_reqs == total_reqs && expected_hashes.size() == 0))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("superfast_hash32_top: mismatch");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    // empty message, single word and multi-word
    queue_req(32'd0, $urandom, 3'd4, 1'b1, 1'b1);
    queue_req(32'd0, 32'hDEAD_BEEF, 3'd4, 1'b1, 1'b0);
    queue_req(32'd5, 32'h0000_FFFF, 3'd2, 1'b0, 1'b1);
    // one-byte tails, negative and positive lone byte
    queue_req(32'd1, 32'hFFFF_FF80, 3'd1, 1'b1, 1'b1);
    queue_req(32'd1, 32'h0000_007F, 3'd1, 1'b1, 1'b1);
    // two- and three-byte tails, lone third byte of both signs
    queue_req(32'd2, 32'h0000_FFFF, 3'd2, 1'b1, 1'b1);
    queue_req(32'd3, 32'hFF80_1234, 3'd3, 1'b1, 1'b1);
    queue_req(32'd3, 32'h007F_FFFF, 3'd3, 1'b1, 1'b1);
    // full words at the extremes, largest length
    queue_req(32'd4, 32'hFFFF_FFFF, 3'd4, 1'b1, 1'b1);
    queue_req(32'hFFFF_FFFF, 32'h0000_0000, 3'd4, 1'b1, 1'b1);
    // zero valid bytes in mid stream and alone
    queue_req(32'd8, 32'h1234_5678, 3'd4, 1'b1, 1'b0);
    queue_req(32'd8, 32'hFFFF_FFFF, 3'd0, 1'b0, 1'b0);
    queue_req(32'd8, 32'h9ABC_DEF0, 3'd4, 1'b0, 1'b1);
    queue_req(32'd5, 32'hFFFF_FFFF, 3'd0, 1'b1, 1'b1);
    // counts above four act as a full word
    queue_req(32'd4, 32'hA5A5_5A5A, 3'd5, 1'b1, 1'b1);
    queue_req(32'd4, 32'hA5A5_5A5A, 3'd6, 1'b1, 1'b1);
    queue_req(32'd4, 32'hA5A5_5A5A, 3'd7, 1'b1, 1'b1);
    // short word that is not last
    queue_req(32'd7, 32'h0080_8080, 3'd3, 1'b1, 1'b0);
    queue_req(32'd7, 32'h8000_0001, 3'd4, 1'b0, 1'b1);
    // no first right after a last: continue from the finished hash
    queue_req(32'hFFFF_FFFF, 32'h0102_0304, 3'd4, 1'b0, 1'b1);
    queue_req(32'd0, 32'h5555_AAAA, 3'd2, 1'b0, 1'b1);
    // length that does not match the words sent
    queue_req(32'd100, 32'h0000_C0DE, 3'd2, 1'b1, 1'b1);

    while (total_reqs < RANDOM_REQS + 22) begin
      if ($urandom_range(99) < 12)
        queue_noise();
      else
        queue_message();
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_reqs != total_reqs || expected_hashes.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && expected_hashes.size() == 0)
      $display("superfast_hash32_top: match");
    else
      $display("superfast_hash32_top: mismatch");
    $finish;
  end

endmodule

FILE: superfast_hash32_top.f
+incdir+design
design/shf32_pkg.sv
design/shf32_front.sv
design/shf32_back.sv
design/shf32_aval.sv
design/superfast_hash32_top.sv
design/shf32_checker.sv
test/testbench.sv
